FILE: rtl/jic_pkg.sv
// Package for the joystick input conditioner.
// Holds the register indexes, the arming and LED mode types and the result item.
// Has no dependencies; the top level refers to it by scoped names.
package jic_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_THR_A        = 3'd0;
  localparam logic [2:0] CFG_THR_B        = 3'd1;
  localparam logic [2:0] CFG_THR_C        = 3'd2;
  localparam logic [2:0] CFG_BLINK_PERIOD = 3'd3;
  localparam logic [2:0] CFG_INVERT_MASK  = 3'd4;

  // Register reset values
  localparam logic [11:0] THR_RESET    = 12'd2048;
  localparam logic [15:0] BLINK_RESET  = 16'd100;
  localparam logic [5:0]  INVERT_RESET = 6'd0;

  // Status word layout
  localparam int MODE_BIT = 9;

  // Result queue
  localparam int RES_DEPTH = 8;
  localparam int RES_AW    = 3;

  typedef enum logic [1:0] {
    ARM_IDLE    = 2'd0,
    ARM_STANDBY = 2'd1,
    ARM_ACTIVE  = 2'd2
  } arm_t;

  typedef enum logic [1:0] {
    LED_OFF  = 2'd0,
    LED_ON   = 2'd1,
    LED_FAST = 2'd2
  } led_t;

  typedef struct packed {
    logic [9:0]  status;
    logic [11:0] avg_a;
    logic [11:0] avg_b;
    logic [11:0] avg_c;
    logic        led;
    logic [1:0]  arm;
  } res_t;

endpackage

FILE: rtl/joystick_input_conditioner.sv
// Joystick input conditioner top level: window memory, moving sums, divider
// by the window length, arming machine, LED blinker and result queue.
// Depends on jic_pkg.
//
// One item is one 1 ms tick. The block takes one item per clock cycle while
// in_stall is low. The window row is read at the edge that accepts the item;
// then the sums update and the row is written back, the multiply by the
// reciprocal of WINDOW lands in the product registers, and last the arm/LED
// logic writes the 8-entry result queue. The three channels of one ring
// position share one row of a single window memory, so each item needs
// exactly one read and one write of that memory; the write lands before the
// same row can be read again. Each window row has a valid bit
// cleared by reset and a row that was never written reads as zero, so there is
// no clearing pass after reset.
// in_stall rises only when the result queue plus the items in flight would
// exceed the queue depth; it comes from registers alone.
module joystick_input_conditioner #(
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 12,
  parameter int TICK_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  button_levels,
  input  logic [11:0] sample_a,
  input  logic [11:0] sample_b,
  input  logic [11:0] sample_c,
  input  logic        mode_pin,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  status_bits,
  output logic [11:0] average_a,
  output logic [11:0] average_b,
  output logic [11:0] average_c,
  output logic        led_level,
  output logic [1:0]  arm_state
);

  localparam int PW   = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int LW   = $clog2(WINDOW);
  localparam int SB   = SAMPLE_BITS;
  localparam int SW   = (SB > 12) ? SB : 12;
  localparam int SUMW = SB + LW;
  localparam int MW   = SUMW + 1;
  localparam int PRW  = SUMW + MW;
  localparam int DK   = SUMW + LW;
  localparam logic [63:0] DIV_POW = 64'd1 << DK;
  localparam logic [63:0] DIV_MUL = (DIV_POW + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] RECIP = DIV_MUL[MW-1:0];

  // ---------------- configuration registers ----------------
  logic [11:0] thr_a, thr_b, thr_c;
  logic [15:0] blink_period;
  logic [5:0]  invert_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_a        <= jic_pkg::THR_RESET;
      thr_b        <= jic_pkg::THR_RESET;
      thr_c        <= jic_pkg::THR_RESET;
      blink_period <= jic_pkg::BLINK_RESET;
      invert_mask  <= jic_pkg::INVERT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jic_pkg::CFG_THR_A:        thr_a        <= cfg_data[11:0];
        jic_pkg::CFG_THR_B:        thr_b        <= cfg_data[11:0];
        jic_pkg::CFG_THR_C:        thr_c        <= cfg_data[11:0];
        jic_pkg::CFG_BLINK_PERIOD: blink_period <= cfg_data;
        jic_pkg::CFG_INVERT_MASK:  invert_mask  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // ---------------- input accept and ring position ----------------
  logic              accept;
  logic [PW-1:0]     ring_pos;
  logic [SW-1:0]     ext_a, ext_b, ext_c;
  logic [3*SB-1:0]   new_row;

  assign accept = in_valid && !in_stall;
  assign ext_a  = SW'(sample_a);
  assign ext_b  = SW'(sample_b);
  assign ext_c  = SW'(sample_c);
  assign new_row = {ext_c[SB-1:0], ext_b[SB-1:0], ext_a[SB-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
    end else if (accept) begin
      if (ring_pos == PW'(WINDOW - 1)) ring_pos <= '0;
      else                             ring_pos <= ring_pos + 1'b1;
    end
  end

  // ---------------- stage 1: window row read ----------------
  logic              v1;
  logic [PW-1:0]     addr1;
  logic [3*SB-1:0]   row1;
  logic [3*SB-1:0]   rd_row;
  logic              rd_vld;
  logic [5:0]        btn1;
  logic              pin1;

  logic [3*SB-1:0]   win_mem [WINDOW];
  logic [WINDOW-1:0] win_vld;

  always_ff @(posedge clk) begin
    if (accept) rd_row <= win_mem[ring_pos];
    if (v1)     win_mem[addr1] <= row1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
    end else if (v1) begin
      win_vld[addr1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr1  <= ring_pos;
      row1   <= new_row;
      rd_vld <= win_vld[ring_pos];
      btn1   <= button_levels;
      pin1   <= mode_pin;
    end
  end

  // ---------------- stage 2: running sums ----------------
  logic [3*SB-1:0] old_row;
  logic [SUMW-1:0] sum [3];
  logic            v2;
  logic [5:0]      btn2;
  logic            pin2;

  // a row never written reads as zeros
  assign old_row = rd_vld ? rd_row : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum[0] <= '0;
      sum[1] <= '0;
      sum[2] <= '0;
      v2     <= 1'b0;
    end else begin
      v2 <= v1;
      if (v1) begin
        for (int i = 0; i < 3; i++) begin
          sum[i] <= sum[i] - SUMW'(old_row[i*SB +: SB]) + SUMW'(row1[i*SB +: SB]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      btn2 <= btn1;
      pin2 <= pin1;
    end
  end

  // ---------------- stage 3: divide by WINDOW via reciprocal ----------------
  logic [PRW-1:0] prod [3];
  logic           v3;
  logic [5:0]     btn3;
  logic           pin3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= PRW'(sum[i]) * PRW'(RECIP);
      end
      btn3 <= btn2;
      pin3 <= pin2;
    end
  end

  // ---------------- stage 4: thresholds, arming machine, LED ----------------
  logic [SB-1:0]  avg [3];
  logic [SW-1:0]  avg_ext [3];
  logic [2:0]     over;
  logic [5:0]     pressed;
  logic           deflected;
  logic           falling;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      avg[i]     = prod[i][DK +: SB];
      avg_ext[i] = SW'(avg[i]);
    end
  end

  assign over[0]   = avg_ext[0] > SW'(thr_a);
  assign over[1]   = avg_ext[1] > SW'(thr_b);
  assign over[2]   = avg_ext[2] > SW'(thr_c);
  assign deflected = over[0];
  assign pressed   = ~btn3 ^ invert_mask;

  jic_pkg::arm_t        arm_mode, arm_next;
  jic_pkg::led_t        led_mode, led_mode_next;
  logic                 led_pin, led_pin_next;
  logic                 prev_pin;
  logic                 mode_flag, mode_flag_next;
  logic [TICK_BITS-1:0] tick_count, tick_next;
  logic [TICK_BITS-1:0] last_toggle, last_toggle_next;
  logic [TICK_BITS-1:0] tick_diff;

  assign falling   = prev_pin && !pin3;
  assign tick_next = tick_count + 1'b1;
  assign tick_diff = tick_next - last_toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_mode    <= jic_pkg::ARM_IDLE;
      led_mode    <= jic_pkg::LED_OFF;
      led_pin     <= 1'b0;
      prev_pin    <= 1'b0;
      mode_flag   <= 1'b0;
      tick_count  <= '0;
      last_toggle <= '0;
    end else if (v3) begin
      arm_mode    <= arm_next;
      led_mode    <= led_mode_next;
      led_pin     <= led_pin_next;
      prev_pin    <= pin3;
      mode_flag   <= mode_flag_next;
      tick_count  <= tick_next;
      last_toggle <= last_toggle_next;
    end
  end

  always_comb begin
    arm_next         = arm_mode;
    led_mode_next    = led_mode;
    mode_flag_next   = mode_flag;
    led_pin_next     = led_pin;
    last_toggle_next = last_toggle;

    // arming: deflection arms, mode pin falling edge swaps standby/active, no deflection in standby disarms
    if (deflected) begin
      case (arm_mode)
        jic_pkg::ARM_IDLE: begin
          arm_next      = jic_pkg::ARM_STANDBY;
          led_mode_next = jic_pkg::LED_FAST;
        end
        jic_pkg::ARM_STANDBY: begin
          if (falling) begin
            arm_next       = jic_pkg::ARM_ACTIVE;
            led_mode_next  = jic_pkg::LED_ON;
            mode_flag_next = 1'b0;
          end else begin
            mode_flag_next = pin3;
          end
        end
        jic_pkg::ARM_ACTIVE: begin
          if (falling) begin
            arm_next       = jic_pkg::ARM_STANDBY;
            led_mode_next  = jic_pkg::LED_FAST;
            mode_flag_next = 1'b0;
          end else begin
            mode_flag_next = pin3;
          end
        end
        default: ;
      endcase
    end else if (arm_mode == jic_pkg::ARM_STANDBY) begin
      arm_next       = jic_pkg::ARM_IDLE;
      led_mode_next  = jic_pkg::LED_OFF;
      mode_flag_next = 1'b0;
    end

    // LED drive; blink timer runs on ticks since the last toggle
    case (led_mode_next)
      jic_pkg::LED_OFF: led_pin_next = 1'b0;
      jic_pkg::LED_ON:  led_pin_next = 1'b1;
      jic_pkg::LED_FAST: begin
        if (tick_diff > TICK_BITS'(blink_period)) begin
          led_pin_next     = ~led_pin;
          last_toggle_next = tick_next;
        end
      end
      default: ;
    endcase
  end

  // assemble the result item
  jic_pkg::res_t res;

  always_comb begin
    res.status                   = '0;
    res.status[0]                = pressed[1];
    res.status[1]                = pressed[0];
    res.status[5:2]              = pressed[5:2];
    res.status[8:6]              = over;
    res.status[jic_pkg::MODE_BIT] = mode_flag_next;
    res.avg_a                    = avg_ext[0][11:0];
    res.avg_b                    = avg_ext[1][11:0];
    res.avg_c                    = avg_ext[2][11:0];
    res.led                      = led_pin_next;
    res.arm                      = arm_next;
  end

  // ---------------- result queue ----------------
  jic_pkg::res_t           res_q [jic_pkg::RES_DEPTH];
  logic [jic_pkg::RES_AW-1:0] wr_ptr, rd_ptr;
  logic [jic_pkg::RES_AW:0]   q_count;
  logic [jic_pkg::RES_AW+1:0] q_load;
  logic                       pop;
  jic_pkg::res_t           head;

  assign pop    = out_valid && !out_stall;
  assign q_load = (jic_pkg::RES_AW+2)'(q_count) + (jic_pkg::RES_AW+2)'(v1)
                + (jic_pkg::RES_AW+2)'(v2) + (jic_pkg::RES_AW+2)'(v3);
  assign in_stall = q_load >= (jic_pkg::RES_AW+2)'(jic_pkg::RES_DEPTH);

  always_ff @(posedge clk) begin
    if (v3) res_q[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (v3)  wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({v3, pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  assign head        = res_q[rd_ptr];
  assign out_valid   = q_count != '0;
  assign status_bits = head.status;
  assign average_a   = head.avg_a;
  assign average_b   = head.avg_b;
  assign average_c   = head.avg_c;
  assign led_level   = head.led;
  assign arm_state   = head.arm;

endmodule
